// ===== rtl/qdd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qdd_pkg
// shared types, constants and the phase table of the detent decoder
// ----------------------------------------------------------------------------
package qdd_pkg;

   // width of the signed detent total
   localparam int COUNT_WIDTH = 8;
   // result field widths
   localparam int STEP_COUNT_WIDTH = 8;
   localparam int LIMIT_WIDTH      = 7;
   // clamp arithmetic width, wide enough for total, limit and a carry
   localparam int CALC_WIDTH = ((COUNT_WIDTH > LIMIT_WIDTH) ? COUNT_WIDTH : LIMIT_WIDTH) + 2;

   // configuration register indexes
   localparam logic CSR_STEP_LIMIT = 1'b0;
   localparam logic CSR_INVERT     = 1'b1;

   localparam logic [LIMIT_WIDTH-1:0] STEP_LIMIT_RESET = LIMIT_WIDTH'(64);

   typedef enum logic [2:0] {
      PH_REST      = 3'd0,
      PH_CW_LAST   = 3'd1,
      PH_CW_FIRST  = 3'd2,
      PH_CW_MID    = 3'd3,
      PH_CCW_FIRST = 3'd4,
      PH_CCW_LAST  = 3'd5,
      PH_CCW_MID   = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      EV_NONE = 2'd0,
      EV_UP   = 2'd1,
      EV_DOWN = 2'd2
   } event_type;

   // one table entry: next phase plus the detent flags
   typedef struct packed {
      phase_type next_phase;
      logic      cw_done;
      logic      ccw_done;
   } entry_type;

   // detent report from the decoder to the counter
   typedef struct packed {
      logic step;   // a full detent cycle completed on this beat
      logic cw;     // direction of that detent, before inversion
   } detent_type;

   function automatic entry_type phase_lookup(input logic [2:0] phase,
                                              input logic [1:0] lines);
      entry_type e;
      e.cw_done  = 1'b0;
      e.ccw_done = 1'b0;
      e.next_phase = PH_REST;
      case (phase)
         PH_CW_LAST: begin
            case (lines)
               2'd0:    e.next_phase = PH_CW_MID;
               2'd1:    e.next_phase = PH_REST;
               2'd2:    e.next_phase = PH_CW_LAST;
               default: begin
                  e.next_phase = PH_REST;
                  e.cw_done    = 1'b1;
               end
            endcase
         end
         PH_CW_FIRST: begin
            case (lines)
               2'd0:    e.next_phase = PH_CW_MID;
               2'd1:    e.next_phase = PH_CW_FIRST;
               default: e.next_phase = PH_REST;
            endcase
         end
         PH_CW_MID: begin
            case (lines)
               2'd0:    e.next_phase = PH_CW_MID;
               2'd1:    e.next_phase = PH_CW_FIRST;
               2'd2:    e.next_phase = PH_CW_LAST;
               default: e.next_phase = PH_REST;
            endcase
         end
         PH_CCW_FIRST: begin
            case (lines)
               2'd0:    e.next_phase = PH_CCW_MID;
               2'd2:    e.next_phase = PH_CCW_FIRST;
               default: e.next_phase = PH_REST;
            endcase
         end
         PH_CCW_LAST: begin
            case (lines)
               2'd0:    e.next_phase = PH_CCW_MID;
               2'd1:    e.next_phase = PH_CCW_LAST;
               2'd2:    e.next_phase = PH_REST;
               default: begin
                  e.next_phase = PH_REST;
                  e.ccw_done   = 1'b1;
               end
            endcase
         end
         PH_CCW_MID: begin
            case (lines)
               2'd0:    e.next_phase = PH_CCW_MID;
               2'd1:    e.next_phase = PH_CCW_LAST;
               2'd2:    e.next_phase = PH_CCW_FIRST;
               default: e.next_phase = PH_REST;
            endcase
         end
         default: begin
            // rest row, also taken by the unused code
            case (lines)
               2'd1:    e.next_phase = PH_CW_FIRST;
               2'd2:    e.next_phase = PH_CCW_FIRST;
               default: e.next_phase = PH_REST;
            endcase
         end
      endcase
      return e;
   endfunction

endpackage

// ===== rtl/qdd_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qdd_decode
// phase register and table step, flags completed detents
// ----------------------------------------------------------------------------
module qdd_decode (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                line_a,
   input  logic                line_b,
   output qdd_pkg::detent_type detent
);

   qdd_pkg::phase_type phase_ff;
   qdd_pkg::phase_type phase_in;
   qdd_pkg::entry_type entry;

   assign entry = qdd_pkg::phase_lookup(phase_ff, {line_a, line_b});

   // next state
   always_comb begin
      phase_in = phase_ff;
      if (advance) begin
         phase_in = entry.next_phase;
      end
   end

   // outputs
   always_comb begin
      detent.step = advance & (entry.cw_done | entry.ccw_done);
      detent.cw   = entry.cw_done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= qdd_pkg::PH_REST;
      end else begin
         phase_ff <= phase_in;
      end
   end

endmodule

// ===== rtl/qdd_counter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qdd_counter
// saturating signed detent total
// ----------------------------------------------------------------------------
module qdd_counter (
   input  logic                                 clock,
   input  logic                                 reset,
   input  qdd_pkg::detent_type                  detent,
   input  logic [qdd_pkg::LIMIT_WIDTH-1:0]      step_limit,
   input  logic                                 invert,
   output logic signed [qdd_pkg::COUNT_WIDTH-1:0] total_next,
   output qdd_pkg::event_type                   step_event
);

   localparam int CW = qdd_pkg::CALC_WIDTH;
   localparam logic signed [CW-1:0] CAP =
      CW'((64'd1 << (qdd_pkg::COUNT_WIDTH - 1)) - 64'd1);

   logic signed [qdd_pkg::COUNT_WIDTH-1:0] total_ff;
   logic signed [qdd_pkg::COUNT_WIDTH-1:0] total_in;
   logic signed [CW-1:0] sum;
   logic signed [CW-1:0] limit_raw;
   logic signed [CW-1:0] limit_eff;
   logic signed [CW-1:0] clamped;
   logic                 up;

   assign up = detent.cw ^ invert;

   always_comb begin
      sum       = CW'(total_ff) + (up ? CW'(1) : -CW'(1));
      limit_raw = signed'(CW'(step_limit));
      limit_eff = (limit_raw > CAP) ? CAP : limit_raw;
      clamped   = sum;
      if (sum > limit_eff) begin
         clamped = limit_eff;
      end else if (sum < -limit_eff) begin
         clamped = -limit_eff;
      end
   end

   always_comb begin
      total_in   = total_ff;
      step_event = qdd_pkg::EV_NONE;
      if (detent.step) begin
         total_in   = qdd_pkg::COUNT_WIDTH'(clamped);
         step_event = up ? qdd_pkg::EV_UP : qdd_pkg::EV_DOWN;
      end
   end

   assign total_next = total_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else begin
         total_ff <= total_in;
      end
   end

endmodule

// ===== rtl/quadrature_detent_decoder.sv =====
`timescale 1ns / 1ps
// an accepted sample beat passes the sample register, then the result register, to rsp_
// throughput: one sample per cycle while rsp_stall is low; the phase table step and
// the saturating add of the total sit together between the sample and result registers
// reset: synchronous, clears the phase to rest, the total to zero, the limit
// to 64 and inversion to off; both stages come out empty
// ----------------------------------------------------------------------------
// quadrature_detent_decoder
// full-step rotary encoder decoder with a saturating signed detent count
// ----------------------------------------------------------------------------
module quadrature_detent_decoder (
   input  logic                                    clock,
   input  logic                                    reset,
   // sample channel
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic                                    req_clk_level,
   input  logic                                    req_dt_level,
   // result channel
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [qdd_pkg::STEP_COUNT_WIDTH-1:0] rsp_step_count,
   output logic [1:0]                              rsp_step_event,
   // register write port
   input  logic                                    csr_wr_en,
   input  logic                                    csr_index,
   input  logic [qdd_pkg::LIMIT_WIDTH-1:0]         csr_wr_data
);

   // configuration registers
   logic [qdd_pkg::LIMIT_WIDTH-1:0] step_limit_ff;
   logic                            invert_ff;

   // sample stage
   logic in_valid_ff;
   logic in_valid_in;
   logic line_a_ff;
   logic line_b_ff;

   // result stage
   logic                                          out_valid_ff;
   logic                                          out_valid_in;
   logic signed [qdd_pkg::STEP_COUNT_WIDTH-1:0]   count_ff;
   qdd_pkg::event_type                            event_ff;

   logic                                          out_free;
   logic                                          advance;
   logic                                          req_take;
   qdd_pkg::detent_type                           detent;
   logic signed [qdd_pkg::COUNT_WIDTH-1:0]        total_next;
   qdd_pkg::event_type                            step_event;

   // result slot is free when empty or being drained this cycle
   assign out_free  = ~out_valid_ff | ~rsp_stall;
   // the held sample moves into the result slot, state advances with it
   assign advance   = in_valid_ff & out_free;
   // sample slot takes a new beat when empty or emptying
   assign req_stall = in_valid_ff & ~out_free;
   assign req_take  = req_valid & ~req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (~rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   // control and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         step_limit_ff <= qdd_pkg::STEP_LIMIT_RESET;
         invert_ff     <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            case (csr_index)
               qdd_pkg::CSR_STEP_LIMIT: step_limit_ff <= csr_wr_data;
               qdd_pkg::CSR_INVERT:     invert_ff     <= csr_wr_data[0];
               default:                 invert_ff     <= invert_ff;
            endcase
         end
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         line_a_ff <= req_clk_level;
         line_b_ff <= req_dt_level;
      end
      if (advance) begin
         count_ff <= qdd_pkg::STEP_COUNT_WIDTH'(total_next);
         event_ff <= step_event;
      end
   end

   qdd_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .line_a  (line_a_ff),
      .line_b  (line_b_ff),
      .detent  (detent)
   );

   qdd_counter u_counter (
      .clock      (clock),
      .reset      (reset),
      .detent     (detent),
      .step_limit (step_limit_ff),
      .invert     (invert_ff),
      .total_next (total_next),
      .step_event (step_event)
   );

   assign rsp_valid      = out_valid_ff;
   assign rsp_step_count = count_ff;
   assign rsp_step_event = event_ff;

endmodule
